@@ hw/rtl/sfh_pkg.sv @@
// ---------------------------------------------------------------------------
// sfh_pkg
// Shared types and mixing functions of the string hash unit.
// ---------------------------------------------------------------------------
package sfh_pkg;

    localparam int HASH_W  = 32;
    localparam int PEND_W  = 24;
    localparam int COUNT_W = 2;

    // pending-byte count at which the next byte completes a group
    localparam logic [COUNT_W-1:0] GROUP_FULL = 2'd3;
    localparam logic [COUNT_W-1:0] TAIL_THREE = 2'd3;
    localparam logic [COUNT_W-1:0] TAIL_TWO   = 2'd2;
    localparam logic [COUNT_W-1:0] TAIL_ONE   = 2'd1;

    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [PEND_W-1:0]  bytes;
        logic [COUNT_W-1:0] count;
    } sfh_snap_t;

    function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
        return {{(HASH_W-8){b[7]}}, b};
    endfunction

    function automatic logic [HASH_W-1:0] mix_group(
        input logic [HASH_W-1:0] h_in,
        input logic [15:0]       lo16,
        input logic [15:0]       hi16
    );
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] t;
        h = h_in + {16'd0, lo16};
        t = ({16'd0, hi16} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
        return h;
    endfunction

    function automatic logic [HASH_W-1:0] mix_tail(
        input logic [HASH_W-1:0]  h_in,
        input logic [PEND_W-1:0]  bytes,
        input logic [COUNT_W-1:0] count
    );
        logic [HASH_W-1:0] h;
        h = h_in;
        case (count)
            TAIL_THREE: begin
                h = h + {16'd0, bytes[15:0]};
                h = h ^ (h << 16);
                h = h ^ (sext8(bytes[23:16]) << 18);
                h = h + (h >> 11);
            end
            TAIL_TWO: begin
                h = h + {16'd0, bytes[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            TAIL_ONE: begin
                h = h + sext8(bytes[7:0]);
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: begin
                h = h_in;
            end
        endcase
        return h;
    endfunction

    // first half of the avalanche finish
    function automatic logic [HASH_W-1:0] aval_a(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in ^ (h_in << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        return h;
    endfunction

    // second half of the avalanche finish
    function automatic logic [HASH_W-1:0] aval_b(input logic [HASH_W-1:0] h_in);
        logic [HASH_W-1:0] h;
        h = h_in + (h_in >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

endpackage

@@ hw/rtl/superfast_string_hash_unit.sv @@
// Result: the hash appears on m_tdata once the last byte's transaction has passed
// the snapshot, tail, avalanche and output registers; other transactions give no result.
// Throughput: one byte per cycle unless the finish holds s_tready low; the group mix
// feeds the running-hash register directly, the finish is a snapshot/tail/aval/out pipeline.
// Reset: synchronous active-low aresetn clears the running hash, pending
// bytes and all pipeline valid flags.
// ---------------------------------------------------------------------------
// superfast_string_hash_unit
// Streaming 32-bit string hash, one key byte per transaction.
// ---------------------------------------------------------------------------
module superfast_string_hash_unit
    import sfh_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [7:0] key_byte, [23:8] key_len
    input  logic [1:0]  s_tuser,    // [0] byte_valid, [1] first_item
    input  logic        s_tlast,    // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [31:0] hash_value, [39:32] bucket_index
);

    localparam logic [32:0] LEN_MASK_W = (33'd1 << LENGTH_BITS) - 33'd1;
    localparam logic [HASH_W-1:0] LEN_MASK = LEN_MASK_W[HASH_W-1:0];

    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic [COUNT_W-1:0] cnt_reg,  cnt_next;

    logic [7:0]         key_byte;
    logic [15:0]        key_len;
    logic               byte_valid, first_item, last_item;
    logic               accept;
    logic               fin_ready;

    logic [HASH_W-1:0]  h0;
    logic [PEND_W-1:0]  p0;
    logic [COUNT_W-1:0] c0;
    sfh_snap_t          snap;

    assign key_byte   = s_tdata[7:0];
    assign key_len    = s_tdata[23:8];
    assign byte_valid = s_tuser[0];
    assign first_item = s_tuser[1];
    assign last_item  = s_tlast;

    assign s_tready = fin_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        h0 = first_item ? ({16'd0, key_len} & LEN_MASK) : hash_reg;
        p0 = first_item ? '0 : pend_reg;
        c0 = first_item ? '0 : cnt_reg;
        snap.hash  = h0;
        snap.bytes = p0;
        snap.count = c0;
        if (byte_valid) begin
            if (c0 == GROUP_FULL) begin
                snap.hash  = mix_group(h0, p0[15:0], {key_byte, p0[23:16]});
                snap.bytes = '0;
                snap.count = '0;
            end else begin
                snap.bytes = p0 | ({16'd0, key_byte} << {c0, 3'b000});
                snap.count = c0 + 2'd1;
            end
        end
        // a finished key leaves the reset state behind
        if (last_item) begin
            hash_next = '0;
            pend_next = '0;
            cnt_next  = '0;
        end else begin
            hash_next = snap.hash;
            pend_next = snap.bytes;
            cnt_next  = snap.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= '0;
            pend_reg <= '0;
            cnt_reg  <= '0;
        end else if (accept) begin
            hash_reg <= hash_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

    sfh_finish u_finish (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid && last_item),
        .in_ready (fin_ready),
        .in_snap  (snap),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_item |=> hash_reg == '0 && pend_reg == '0 && cnt_reg == '0)
        else $error("state not cleared after last byte");

    a_pend_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && pend_reg == '0) || (cnt_reg == 2'd1 && pend_reg[23:8] == '0)
        || (cnt_reg == 2'd2 && pend_reg[23:16] == '0) || cnt_reg == 2'd3)
        else $error("pending bytes hold data above their count");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && byte_valid && !first_item && !last_item && cnt_reg != GROUP_FULL
        |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("pending count did not advance on a byte");

endmodule

@@ hw/rtl/sfh_finish.sv @@
// ---------------------------------------------------------------------------
// sfh_finish
// Tail mix and avalanche finish of a completed key, in a stallable pipeline.
// ---------------------------------------------------------------------------
module sfh_finish
    import sfh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  sfh_snap_t   in_snap,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] hash_value, [39:32] bucket_index
);

    logic              snap_v_reg, tail_v_reg, aval_v_reg, out_v_reg;
    sfh_snap_t         snap_reg;
    logic [HASH_W-1:0] tail_reg;
    logic [HASH_W-1:0] aval_reg;
    logic [HASH_W-1:0] out_reg;

    logic ld_out, ld_aval, ld_tail, ld_snap;

    assign ld_out  = !out_v_reg  || m_tready;
    assign ld_aval = !aval_v_reg || ld_out;
    assign ld_tail = !tail_v_reg || ld_aval;
    assign ld_snap = !snap_v_reg || ld_tail;
    assign in_ready = ld_snap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
            aval_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if (ld_snap) snap_v_reg <= in_valid;
            if (ld_tail) tail_v_reg <= snap_v_reg;
            if (ld_aval) aval_v_reg <= tail_v_reg;
            if (ld_out)  out_v_reg  <= aval_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_snap) snap_reg <= in_snap;
        if (ld_tail) tail_reg <= mix_tail(snap_reg.hash, snap_reg.bytes, snap_reg.count);
        if (ld_aval) aval_reg <= aval_a(tail_reg);
        if (ld_out)  out_reg  <= aval_b(aval_reg);
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg[7:0], out_reg};

    a_snap_load: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> snap_v_reg)
        else $error("accepted key not captured in snapshot stage");

    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_v_reg && !ld_tail |=> snap_v_reg && $stable(snap_reg))
        else $error("stalled snapshot lost or changed");

    a_aval_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        aval_v_reg && ld_out |=> out_v_reg)
        else $error("finished hash not moved to output");

endmodule

@@ bench/superfast_string_hash_unit_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// superfast_string_hash_unit_test
// Streams keys into the hash unit byte by byte and checks every emitted hash
// and bucket against a local model of the running hash, with random idling
// on both sides, a long output stall and a drained pause.
// ---------------------------------------------------------------------------
module superfast_string_hash_unit_test;
    import sfh_pkg::*;

    localparam int CLK_PERIOD = 12;

    typedef struct packed {
        logic [7:0]  kb;
        logic        has_byte;
        logic        is_first;
        logic [15:0] klen;
        logic        is_last;
    } key_item_t;

    typedef struct packed {
        logic [31:0] hash;
        logic [7:0]  bucket;
    } hash_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [7:0] key_byte, [23:8] key_len
    logic [1:0]  s_tuser;    // [0] byte_valid, [1] first_item
    logic        s_tlast;    // last_item
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [31:0] hash_value, [39:32] bucket_index

    // local copy of the running hash state
    logic [31:0] acc_hash;
    logic [23:0] acc_bytes;
    logic [1:0]  acc_cnt;

    hash_res_t   hash_q[$];
    hash_res_t   want_res;
    int          n_errors;
    int          n_items;
    bit          idle_on;
    int          hold_cycles;

    superfast_string_hash_unit #(
        .LENGTH_BITS(16)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic logic [31:0] widen_signed(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    // advances the local state by one transaction, returns 1 when a hash is due
    function automatic bit hash_step(input key_item_t it, output logic [31:0] h);
        logic [31:0] x;
        logic [31:0] t;
        logic [15:0] hi;
        h = '0;
        if (it.is_first) begin
            acc_hash  = {16'd0, it.klen};
            acc_bytes = '0;
            acc_cnt   = '0;
        end
        if (it.has_byte) begin
            if (acc_cnt == GROUP_FULL) begin
                hi = {it.kb, acc_bytes[23:16]};
                x = acc_hash + {16'd0, acc_bytes[15:0]};
                t = ({16'd0, hi} << 11) ^ x;
                x = (x << 16) ^ t;
                acc_hash  = x + (x >> 11);
                acc_bytes = '0;
                acc_cnt   = '0;
            end else begin
                acc_bytes[8*acc_cnt +: 8] = it.kb;
                acc_cnt = acc_cnt + 2'd1;
            end
        end
        if (!it.is_last) return 1'b0;
        x = acc_hash;
        case (acc_cnt)
            TAIL_THREE: begin
                x = x + {16'd0, acc_bytes[15:0]};
                x = x ^ (x << 16);
                x = x ^ (widen_signed(acc_bytes[23:16]) << 18);
                x = x + (x >> 11);
            end
            TAIL_TWO: begin
                x = x + {16'd0, acc_bytes[15:0]};
                x = x ^ (x << 11);
                x = x + (x >> 17);
            end
            TAIL_ONE: begin
                x = x + widen_signed(acc_bytes[7:0]);
                x = x ^ (x << 10);
                x = x + (x >> 1);
            end
            default: begin
            end
        endcase
        // avalanche
        x = x ^ (x << 3);
        x = x + (x >> 5);
        x = x ^ (x << 4);
        x = x + (x >> 17);
        x = x ^ (x << 25);
        x = x + (x >> 6);
        h = x;
        acc_hash  = '0;
        acc_bytes = '0;
        acc_cnt   = '0;
        return 1'b1;
    endfunction

    // call it just after the rising clock; returns once the unit has taken the transaction
    task automatic send_item(input logic [7:0] kb, input logic has_byte, input logic is_first,
                             input logic [15:0] klen, input logic is_last);
        key_item_t   it;
        logic [31:0] h;
        hash_res_t   r;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {klen, kb};
        s_tuser  <= {is_first, has_byte};
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        it = '{kb: kb, has_byte: has_byte, is_first: is_first, klen: klen, is_last: is_last};
        if (hash_step(it, h)) begin
            r.hash   = h;
            r.bucket = h[7:0];
            hash_q.push_back(r);
        end
        n_items++;
    endtask

    // a whole key: byte i (mod 8) from pat, or random content when rnd is set
    task automatic send_key(input int n, input logic [15:0] klen, input logic [63:0] pat,
                            input bit rnd);
        logic [7:0] b;
        if (n == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1, klen, 1'b1);
        end else begin
            for (int i = 0; i < n; i++) begin
                b = rnd ? 8'($urandom) : pat[8*(i%8) +: 8];
                send_item(b, 1'b1, i == 0, klen, i == n - 1);
            end
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (hash_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_edge_keys();
        send_key(0, 16'h0000, 64'h0, 1'b0);
        send_key(0, 16'hFFFF, 64'h0, 1'b0);
        send_key(1, 16'd1, 64'h80, 1'b0);
        send_key(1, 16'd1, 64'h7F, 1'b0);
        // length that does not match the bytes streamed
        send_key(2, 16'hFFFF, 64'hFFFF, 1'b0);
        send_key(3, 16'd3, 64'h80_3412, 1'b0);
        send_key(3, 16'd3, 64'h00_FF80, 1'b0);
        send_key(4, 16'd4, 64'hFF00_FF00, 1'b0);
        send_key(5, 16'd5, 64'hFF_0403_0201, 1'b0);
        // byte marked invalid in the middle of a key
        send_item(8'hAA, 1'b1, 1'b1, 16'd2, 1'b0);
        send_item(8'h55, 1'b0, 1'b0, 16'hFFFF, 1'b0);
        send_item(8'hBB, 1'b1, 1'b0, 16'h0000, 1'b1);
        // key without a first transaction
        send_item(8'hC3, 1'b1, 1'b0, 16'd9, 1'b0);
        send_item(8'h3C, 1'b1, 1'b0, 16'd9, 1'b1);
        // restart in the middle of a key
        send_item(8'h11, 1'b1, 1'b1, 16'd7, 1'b0);
        send_item(8'h22, 1'b1, 1'b1, 16'd9, 1'b1);
    endtask

    task automatic test_output_stall();
        hold_cycles = 64;
        repeat (40) send_key($urandom_range(0, 3), 16'($urandom_range(0, 3)), 64'h0, 1'b1);
        // sender stops until the unit has given back every hash
        wait_for_results();
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic test_random_keys(input int upto);
        int          mode;
        int          n;
        int          m;
        logic [15:0] klen;
        while (n_items < upto) begin
            mode = $urandom_range(0, 9);
            if (mode <= 7) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
                klen = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'(n);
                send_key(n, klen, 64'h0, 1'b1);
            end else if (mode == 8) begin
                send_item(8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                          1'($urandom));
            end else begin
                // broken key: no first transaction, invalid bytes mixed in
                m = $urandom_range(1, 6);
                for (int i = 0; i < m; i++)
                    send_item(8'($urandom), 1'($urandom), 1'b0, 16'($urandom), i == m - 1);
            end
        end
    endtask

    // receiver: random hold-offs, plus the long one that the stall test asks for
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (hash_q.size() == 0) begin
                $display("%0t: hash with none expected, expected none, actual %h", $time,
                         m_tdata);
                n_errors++;
            end else begin
                want_res = hash_q.pop_front();
                if (m_tdata[31:0] !== want_res.hash) begin
                    $display("%0t: hash_value mismatch, expected %h, actual %h", $time,
                             want_res.hash, m_tdata[31:0]);
                    n_errors++;
                end
                if (m_tdata[39:32] !== want_res.bucket) begin
                    $display("%0t: bucket_index mismatch, expected %h, actual %h", $time,
                             want_res.bucket, m_tdata[39:32]);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #(CLK_PERIOD * 600000);
        $display("superfast_string_hash_unit_test: errors");
        $finish;
    end

    initial begin
        n_errors    = 0;
        n_items     = 0;
        idle_on     = 1'b1;
        hold_cycles = 0;
        acc_hash    = '0;
        acc_bytes   = '0;
        acc_cnt     = '0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edge_keys();
        test_output_stall();
        test_random_keys(1100);
        // no idling on either side for the last part
        idle_on = 1'b0;
        test_random_keys(1400);

        wait_for_results();
        repeat (10) @(posedge aclk);
        if (n_errors == 0) begin
            $display("superfast_string_hash_unit_test: clean");
        end else begin
            $display("superfast_string_hash_unit_test: errors");
        end
        $finish;
    end

endmodule
